/* src/dtl_pkg.sv */
// ----------------------------------------------------------------------------
// Decision tree leaf lookup package
// Shared constants, payload layouts, command/status bundles and the
// constant-divisor helpers used by the feature decode.
// ----------------------------------------------------------------------------
package dtl_pkg;

   localparam int NODE_COUNT        = 4096;
   localparam int MAX_DEPTH         = 64;
   localparam int WORDS_PER_PATTERN = 23;
   localparam int PATTERN_COUNT     = 625;
   localparam int FEATURE_WORDS     = PATTERN_COUNT * WORDS_PER_PATTERN;
   localparam int INVENTORY_WORDS   = PATTERN_COUNT * 10;
   localparam int FAMILY_LIMIT      = 4800000;
   localparam int LOCAL_FEATURES    = 9;

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int FEAT_AW = $clog2(FEATURE_WORDS);
   localparam int INV_AW  = $clog2(INVENTORY_WORDS);
   localparam int STEP_W  = $clog2(MAX_DEPTH + 1);

   localparam int REQ_W  = 144;
   localparam int RSP_W  = 16;
   localparam int MODE_W = 2;

   typedef enum logic [1:0] {
      MODE_NODE     = 2'd0,
      MODE_FEAT     = 2'd1,
      MODE_INV      = 2'd2,
      MODE_CLASSIFY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_DEPTH  = 2'd1,
      FAULT_DOMAIN = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INV_RD,
      ST_INV_LD,
      ST_NODE,
      ST_FEAT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DEC_DIV6 = 3'd0,
      DEC_DIV5 = 3'd1,
      DEC_DIV2 = 3'd2,
      DEC_DIG0 = 3'd3,
      DEC_DIG1 = 3'd4,
      DEC_DIG2 = 3'd5,
      DEC_DIG3 = 3'd6
   } dec_step_type;

   // request payload, last member in the lowest bits
   typedef struct packed {
      logic               pad;
      logic [11:0]        root;
      logic [22:0]        family;
      logic signed [63:0] word_value;
      logic [11:0]        right_child;
      logic [11:0]        left_child;
      logic signed [5:0]  split_feature;
      logic [13:0]        index;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic [1:0]  fault;
      logic [11:0] leaf;
   } rsp_data_type;

   typedef struct packed {
      logic signed [5:0]  split;
      logic [11:0]        left;
      logic [11:0]        right;
      logic signed [63:0] limit;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic         wr_node;
      logic         wr_feat;
      logic         wr_inv;
      logic         start;
      logic         dec_en;
      dec_step_type dec_step;
      logic         inv_rd;
      logic         inv_ld;
      logic         node_rd;
      logic         feat_rd;
      logic         take_child;
      logic         use_pat;
      logic         load_rsp;
      fault_type    rsp_fault;
   } ctrl_cmd_type;

   typedef struct packed {
      logic family_bad;
      logic leaf;
      logic feat_remote;
      logic rsp_free;
   } dp_status_type;

   // floor(x/6) for any 16-bit x: reciprocal multiply, exact over the range
   function automatic logic [15:0] div6_u16(input logic [15:0] x);
      logic [33:0] p;
      p = {18'd0, x} * 34'd43691;
      return p[33:18];
   endfunction

   // floor(x/5) for any 16-bit x
   function automatic logic [15:0] div5_u16(input logic [15:0] x);
      logic [33:0] p;
      p = {18'd0, x} * 34'd52429;
      return p[33:18];
   endfunction

endpackage

/* src/dtl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dtl_ctrl.sv */
// ----------------------------------------------------------------------------
// Decision tree leaf lookup controller
// Sequences writes, feature decode, inventory fetch, tree walk and result.
// ----------------------------------------------------------------------------
module dtl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dtl_pkg::mode_type      req_mode,
   input  dtl_pkg::dp_status_type status,
   output dtl_pkg::ctrl_cmd_type  cmd
);
   import dtl_pkg::*;

   state_type        state_ff, state_in;
   dec_step_type     dec_ff, dec_in;
   logic [STEP_W-1:0] depth_ff, depth_in;
   fault_type        fault_ff, fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dec_ff   <= DEC_DIV6;
         depth_ff <= '0;
         fault_ff <= FAULT_NONE;
      end else begin
         state_ff <= state_in;
         dec_ff   <= dec_in;
         depth_ff <= depth_in;
         fault_ff <= fault_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      dec_in        = dec_ff;
      depth_in      = depth_ff;
      fault_in      = fault_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.dec_step  = dec_ff;
      cmd.rsp_fault = fault_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_mode)
                  MODE_NODE: cmd.wr_node = 1'b1;
                  MODE_FEAT: cmd.wr_feat = 1'b1;
                  MODE_INV:  cmd.wr_inv  = 1'b1;
                  MODE_CLASSIFY: begin
                     if (status.family_bad) begin
                        fault_in = FAULT_DOMAIN;
                        state_in = ST_DONE;
                     end else begin
                        cmd.start = 1'b1;
                        dec_in    = DEC_DIV6;
                        state_in  = ST_DECODE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DECODE: begin
            cmd.dec_en = 1'b1;
            if (dec_ff == DEC_DIG3) begin
               state_in = ST_INV_RD;
            end else begin
               dec_in = dec_step_type'(dec_ff + 3'd1);
            end
         end
         ST_INV_RD: begin
            cmd.inv_rd = 1'b1;
            state_in   = ST_INV_LD;
         end
         ST_INV_LD: begin
            cmd.inv_ld  = 1'b1;
            cmd.node_rd = 1'b1;
            depth_in    = '0;
            state_in    = ST_NODE;
         end
         ST_NODE: begin
            if (status.leaf) begin
               fault_in = FAULT_NONE;
               state_in = ST_DONE;
            end else if (depth_ff >= STEP_W'(MAX_DEPTH)) begin
               fault_in = FAULT_DEPTH;
               state_in = ST_DONE;
            end else if (status.feat_remote) begin
               cmd.feat_rd = 1'b1;
               state_in    = ST_FEAT;
            end else begin
               cmd.take_child = 1'b1;
               depth_in       = depth_ff + STEP_W'(1);
            end
         end
         ST_FEAT: begin
            cmd.take_child = 1'b1;
            cmd.use_pat    = 1'b1;
            depth_in       = depth_ff + STEP_W'(1);
            state_in       = ST_NODE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* src/dtl_datapath.sv */
// ----------------------------------------------------------------------------
// Decision tree leaf lookup datapath
// Node, pattern and inventory memories, mixed-radix decode, compare and
// output register.
// ----------------------------------------------------------------------------
module dtl_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [dtl_pkg::REQ_W-1:0]  req_tdata,
   input  dtl_pkg::ctrl_cmd_type      cmd,
   output dtl_pkg::dp_status_type     status,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dtl_pkg::RSP_W-1:0]  rsp_tdata
);
   import dtl_pkg::*;

   req_data_type req;
   assign req = req_tdata;

   // decode registers
   logic [15:0] val_ff;
   logic [7:0]  f7_ff;
   logic [2:0]  f6_ff;
   logic [2:0]  f4_ff;
   logic        f5_ff;
   logic [2:0]  dig_ff [4];
   logic [9:0]  pat_ff;
   logic [19:0] f8_ff;
   logic [11:0] at_ff;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   // memories
   node_type            node_wr, node_rd;
   logic [NODE_W-1:0]   node_rd_raw;
   logic                node_rd_en;
   logic [NODE_AW-1:0]  node_rd_addr;
   logic signed [63:0]  pat_rd;
   logic [FEAT_AW-1:0]  pat_rd_addr;
   logic [19:0]         inv_rd;
   logic [INV_AW-1:0]   inv_rd_addr;

   logic wr_node_ok, wr_feat_ok, wr_inv_ok;

   assign wr_node_ok = cmd.wr_node && (int'(req.index) < NODE_COUNT);
   assign wr_feat_ok = cmd.wr_feat && (int'(req.index) < FEATURE_WORDS);
   assign wr_inv_ok  = cmd.wr_inv  && (int'(req.index) < INVENTORY_WORDS);

   assign node_wr.split = req.split_feature;
   assign node_wr.left  = req.left_child;
   assign node_wr.right = req.right_child;
   assign node_wr.limit = req.word_value;
   assign node_rd       = node_rd_raw;

   dtl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_node_ok),
      .wr_addr (NODE_AW'(req.index)),
      .wr_data (node_wr),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_raw)
   );

   dtl_ram #(.WIDTH(64), .DEPTH(FEATURE_WORDS)) u_pat_ram (
      .clock   (clock),
      .wr_en   (wr_feat_ok),
      .wr_addr (FEAT_AW'(req.index)),
      .wr_data (req.word_value),
      .rd_en   (cmd.feat_rd),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd)
   );

   dtl_ram #(.WIDTH(20), .DEPTH(INVENTORY_WORDS)) u_inv_ram (
      .clock   (clock),
      .wr_en   (wr_inv_ok),
      .wr_addr (INV_AW'(req.index)),
      .wr_data (req.word_value[19:0]),
      .rd_en   (cmd.inv_rd),
      .rd_addr (inv_rd_addr),
      .rd_data (inv_rd)
   );

   // one mixed-radix digit per decode step
   logic [15:0] quot;
   logic [2:0]  divisor;
   logic [15:0] rem_full;
   logic [2:0]  rem;

   always_comb begin
      case (cmd.dec_step)
         DEC_DIV6: begin
            quot    = div6_u16(val_ff);
            divisor = 3'd6;
         end
         DEC_DIV2: begin
            quot    = val_ff >> 1;
            divisor = 3'd2;
         end
         default: begin
            quot    = div5_u16(val_ff);
            divisor = 3'd5;
         end
      endcase
      rem_full = val_ff - quot * {13'd0, divisor};
      rem      = rem_full[2:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         val_ff <= req.family[22:7];
         f7_ff  <= {1'b0, req.family[6:0]} + 8'd1;
      end else if (cmd.dec_en) begin
         val_ff <= quot;
         case (cmd.dec_step)
            DEC_DIV6: f6_ff <= rem;
            DEC_DIV5: f4_ff <= rem;
            DEC_DIV2: begin
               f5_ff  <= rem[0];
               pat_ff <= quot[9:0];
            end
            DEC_DIG0: dig_ff[0] <= rem;
            DEC_DIG1: dig_ff[1] <= rem;
            DEC_DIG2: dig_ff[2] <= rem;
            DEC_DIG3: dig_ff[3] <= rem;
            default: ;
         endcase
      end
      if (cmd.inv_ld) begin
         f8_ff <= inv_rd;
      end
   end

   // inventory word: pattern*10 + d4*2 + d5
   assign inv_rd_addr = INV_AW'({pat_ff, 3'd0} + {2'd0, pat_ff, 1'b0}
                                + {8'd0, f4_ff, 1'b0} + {12'd0, f5_ff});

   // pattern word: pattern*23 + (split - 9)
   logic [14:0] pat_base;
   assign pat_base    = 15'(pat_ff) * 15'd23;
   assign pat_rd_addr = FEAT_AW'(pat_base + 15'(node_rd.split[4:0])
                                 - 15'(LOCAL_FEATURES));

   // feature select and compare
   logic signed [63:0] local_feat, feat;
   logic               go_left;
   logic [11:0]        child;

   always_comb begin
      case (node_rd.split[4:0])
         5'd0:    local_feat = 64'(dig_ff[0]);
         5'd1:    local_feat = 64'(dig_ff[1]);
         5'd2:    local_feat = 64'(dig_ff[2]);
         5'd3:    local_feat = 64'(dig_ff[3]);
         5'd4:    local_feat = 64'(f4_ff);
         5'd5:    local_feat = 64'(f5_ff);
         5'd6:    local_feat = 64'(f6_ff);
         5'd7:    local_feat = 64'(f7_ff);
         default: local_feat = 64'(f8_ff);
      endcase
      feat    = cmd.use_pat ? pat_rd : local_feat;
      go_left = feat <= node_rd.limit;
      child   = go_left ? node_rd.left : node_rd.right;
   end

   assign node_rd_en   = cmd.node_rd | cmd.take_child;
   assign node_rd_addr = cmd.take_child ? NODE_AW'(child) : NODE_AW'(at_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         at_ff <= req.root;
      end else if (cmd.take_child) begin
         at_ff <= child;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.pad   <= '0;
         rsp_data_ff.fault <= cmd.rsp_fault;
         rsp_data_ff.leaf  <= (cmd.rsp_fault == FAULT_DOMAIN) ? 12'd0 : at_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.family_bad  = int'(req.family) >= FAMILY_LIMIT;
   assign status.leaf        = node_rd.split[5] || (int'(at_ff) >= NODE_COUNT);
   assign status.feat_remote = node_rd.split[4:0] >= 5'(LOCAL_FEATURES);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

endmodule

/* src/decision_tree_leaf_lookup_core.sv */
// ----------------------------------------------------------------------------
// Decision tree leaf lookup core
// Tree inference engine: loads node, pattern and inventory memories and
// walks a tree from a root to a leaf for each classify transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per item; req_tuser selects the kind:
//   write node, write pattern word, write inventory word, or classify.
//   Write transactions are taken one per cycle while the controller is idle and produce no rsp.
//   A classify transaction produces exactly one rsp transaction holding the
//   leaf reached and a fault code (ok, depth limit hit, family out of range).
// Steps of a classify: the mixed-radix decode of the family, the inventory
//   read and load along with the root node read, then per tree level a
//   compare and child node read, with an extra pattern-memory read first
//   for a level that compares against a pattern word (node memory to
//   pattern memory), then the leaf is seen and the result is loaded into
//   the output register once it is free. An out-of-range family skips the
//   decode and the walk and goes straight to the output register.
// req_tready is high only while the controller is idle; one classify is in
//   flight at a time. The result sits in an output register, so the next
//   transaction is taken while rsp waits; a stalled rsp holds its payload.
// Reset clears the control state and the rsp valid flag; memories keep their
//   contents and must be written before they are read.
// ----------------------------------------------------------------------------
module decision_tree_leaf_lookup_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // index, split_feature, left_child, right_child, word_value, family, root
   input  logic [dtl_pkg::REQ_W-1:0]          req_tdata,
   // mode
   input  logic [dtl_pkg::MODE_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // leaf, fault
   output logic [dtl_pkg::RSP_W-1:0]          rsp_tdata
);
   import dtl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   mode_type      req_mode;

   // kind of transaction taken straight from the sideband
   assign req_mode = mode_type'(req_tuser);

   dtl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_mode),
      .status     (status),
      .cmd        (cmd)
   );

   dtl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* src/dtl_checker.sv */
// ----------------------------------------------------------------------------
// Decision tree leaf lookup checker
// Port-level checks on the rsp channel, bound to the core.
// ----------------------------------------------------------------------------
module dtl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [dtl_pkg::RSP_W-1:0] rsp_tdata
);
   import dtl_pkg::*;

   // hold a stalled transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:12] != 2'd3))
      else $error("rsp fault code undefined");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[13:12] == FAULT_DOMAIN) |-> (rsp_tdata[11:0] == 12'd0))
      else $error("out of domain family reported a nonzero leaf");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind decision_tree_leaf_lookup_core dtl_checker u_dtl_checker (.*);
